FILE: rtl/vnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vnp_pkg;

  // reset value of the connection id length limit
  localparam logic [7:0] CID_LIMIT_RESET = 8'd20;

  // result kinds
  typedef enum logic [2:0] {
    K_DCID = 3'd0,
    K_SCID = 3'd1,
    K_WORD = 3'd2,
    K_END  = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  // status codes
  typedef enum logic [2:0] {
    S_OK        = 3'd0,
    S_VER_NZ    = 3'd1,
    S_DCID_LONG = 3'd2,
    S_SCID_LONG = 3'd3,
    S_TRUNC     = 3'd4
  } status_t;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_VER  = 6'b000001,
    PH_DLEN = 6'b000010,
    PH_DCID = 6'b000100,
    PH_SLEN = 6'b001000,
    PH_SCID = 6'b010000,
    PH_LIST = 6'b100000
  } phase_t;

  // one packet byte held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [15:0] position;
    status_t     status;
    logic        last;
  } res_t;

  // parser state
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  field_remaining;
    logic [1:0]  byte_in_word;
    logic [23:0] word_accumulator;
    logic [15:0] word_index;
    logic        discarding;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:            PH_VER,
    field_remaining:  8'd0,
    byte_in_word:     2'd0,
    word_accumulator: 24'd0,
    word_index:       16'd0,
    discarding:       1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/vnp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module vnp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  output logic                   s_ready,
  input  wire vnp_pkg::in_item_t s_item,
  output logic                   item_valid,
  output vnp_pkg::in_item_t      item,
  input  wire logic              advance
);
  import vnp_pkg::*;

  logic load;

  // stage can take a byte when empty or when its byte moves on
  assign s_ready = !item_valid || advance;
  assign load    = s_valid && s_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vnp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module vnp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cid_limit_wr_en,
  input  wire logic [7:0]        cid_limit_wr_data,
  input  wire logic              fire,
  input  wire vnp_pkg::in_item_t item,
  output logic                   res_valid,
  output vnp_pkg::res_t          res
);
  import vnp_pkg::*;

  logic [7:0] cid_limit;
  st_t        st;
  st_t        st_next;
  st_t        st_work;
  logic       do_fail;
  status_t    fail_status;
  logic       do_restart;
  logic [7:0] b;
  logic       pend;

  assign b    = item.data_byte;
  assign pend = item.packet_end;

  // connection id length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      cid_limit <= CID_LIMIT_RESET;
    end else if (cid_limit_wr_en) begin
      cid_limit <= cid_limit_wr_data;
    end
  end

  // per-byte state update and result
  always_comb begin
    st_work     = st;
    res_valid   = 1'b0;
    res         = '{kind: K_DCID, value: 32'd0, position: 16'd0, status: S_OK, last: 1'b0};
    do_fail     = 1'b0;
    fail_status = S_OK;
    do_restart  = 1'b0;

    if (st.discarding) begin
      // drop bytes until the packet ends
      do_restart = pend;
    end else begin
      unique case (st.phase)
        PH_DLEN: begin
          if (b > cid_limit) begin
            do_fail     = 1'b1;
            fail_status = S_DCID_LONG;
          end else if (pend) begin
            do_fail     = 1'b1;
            fail_status = S_TRUNC;
          end else begin
            st_work.field_remaining = b;
            st_work.word_index      = 16'd0;
            st_work.phase           = (b != 8'd0) ? PH_DCID : PH_SLEN;
          end
        end
        PH_DCID: begin
          if (pend) begin
            do_fail     = 1'b1;
            fail_status = S_TRUNC;
          end else begin
            res_valid               = 1'b1;
            res.kind                = K_DCID;
            res.value               = {24'd0, b};
            res.position            = st.word_index;
            st_work.word_index      = st.word_index + 16'd1;
            st_work.field_remaining = st.field_remaining - 8'd1;
            if (st.field_remaining == 8'd1) begin
              st_work.phase = PH_SLEN;
            end
          end
        end
        PH_SLEN: begin
          if (b > cid_limit) begin
            do_fail     = 1'b1;
            fail_status = S_SCID_LONG;
          end else if (pend) begin
            if (b != 8'd0) begin
              do_fail     = 1'b1;
              fail_status = S_TRUNC;
            end else begin
              res_valid  = 1'b1;
              res.kind   = K_END;
              res.last   = 1'b1;
              do_restart = 1'b1;
            end
          end else begin
            st_work.field_remaining  = b;
            st_work.word_index       = 16'd0;
            st_work.byte_in_word     = 2'd0;
            st_work.word_accumulator = 24'd0;
            st_work.phase            = (b != 8'd0) ? PH_SCID : PH_LIST;
          end
        end
        PH_SCID: begin
          if (pend && st.field_remaining != 8'd1) begin
            do_fail     = 1'b1;
            fail_status = S_TRUNC;
          end else begin
            res_valid    = 1'b1;
            res.kind     = K_SCID;
            res.value    = {24'd0, b};
            res.position = st.word_index;
            res.last     = pend;
            if (pend) begin
              do_restart = 1'b1;
            end else if (st.field_remaining == 8'd1) begin
              st_work.field_remaining  = 8'd0;
              st_work.phase            = PH_LIST;
              st_work.word_index       = 16'd0;
              st_work.byte_in_word     = 2'd0;
              st_work.word_accumulator = 24'd0;
            end else begin
              st_work.word_index      = st.word_index + 16'd1;
              st_work.field_remaining = st.field_remaining - 8'd1;
            end
          end
        end
        PH_LIST: begin
          if (st.byte_in_word != 2'd3) begin
            st_work.word_accumulator = {st.word_accumulator[15:0], b};
            st_work.byte_in_word     = st.byte_in_word + 2'd1;
            if (pend) begin
              // partial word at the end is dropped
              res_valid    = 1'b1;
              res.kind     = K_END;
              res.position = st.word_index;
              res.last     = 1'b1;
              do_restart   = 1'b1;
            end
          end else begin
            res_valid    = 1'b1;
            res.kind     = K_WORD;
            res.value    = {st.word_accumulator, b};
            res.position = st.word_index;
            res.last     = pend;
            if (st.word_index != 16'hFFFF) begin
              st_work.word_index = st.word_index + 16'd1;
            end
            st_work.byte_in_word     = 2'd0;
            st_work.word_accumulator = 24'd0;
            do_restart               = pend;
          end
        end
        default: begin
          // version field, also any unused phase code
          if (st.byte_in_word != 2'd3) begin
            st_work.word_accumulator = {st.word_accumulator[15:0], b};
            st_work.byte_in_word     = st.byte_in_word + 2'd1;
            st_work.phase            = PH_VER;
            if (pend) begin
              do_fail     = 1'b1;
              fail_status = S_TRUNC;
            end
          end else begin
            st_work.byte_in_word     = 2'd0;
            st_work.word_accumulator = 24'd0;
            if (st.word_accumulator != 24'd0 || b != 8'd0) begin
              do_fail     = 1'b1;
              fail_status = S_VER_NZ;
            end else if (pend) begin
              do_fail     = 1'b1;
              fail_status = S_TRUNC;
            end else begin
              st_work.phase = PH_DLEN;
            end
          end
        end
      endcase
    end

    // error result replaces anything else, then drop the rest of the packet
    st_next = st_work;
    if (do_fail) begin
      res_valid          = 1'b1;
      res                = '{kind: K_ERR, value: 32'd0, position: 16'd0,
                             status: fail_status, last: 1'b1};
      st_next            = ST_RESET;
      st_next.discarding = !pend;
    end else if (do_restart) begin
      st_next = ST_RESET;
    end
  end

  // state register, moves once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // every packet end leaves the parser at its start state
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && pend |=> st.phase == PH_VER && !st.discarding && st.byte_in_word == 2'd0)
    else $error("packet end did not restart the parser");

  // error and end results always close the packet
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == K_ERR || res.kind == K_END) |-> res.last)
    else $error("closing result without last");

  // state holds while no byte is processed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("parser state moved without a byte");

  // partial word bytes only exist in the version and list phases
  a_biw_phase: assert property (@(posedge clk) disable iff (rst)
    st.byte_in_word != 2'd0 |-> st.phase == PH_VER || st.phase == PH_LIST)
    else $error("word byte count outside version or list phase");

endmodule

`default_nettype wire

FILE: rtl/vnp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module vnp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire vnp_pkg::res_t res_in,
  output logic               space,
  output logic               m_valid,
  input  wire logic          m_ready,
  output vnp_pkg::res_t      m_res
);
  import vnp_pkg::*;

  // register is free when empty or being taken this cycle
  assign space = !m_valid || m_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/version_negotiation_parser_top.sv
// Version negotiation packet parser.
// Slave stream: one packet byte per transaction in s_tdata, starting after the
// flag byte, with s_tlast on the final byte of the packet.
// Master stream: zero or one result per byte. m_tuser carries the kind
// (dcid byte, scid byte, supported version, end, error), m_tdata the value,
// position and status, m_tlast marks the final result of a packet.
// The user must write the connection id length limit through cid_limit_wr_en and
// cid_limit_wr_data only while no packet byte is in flight; not enforced here.
// Throughput is one byte per cycle while the receiver keeps taking results:
// the byte register, the single state update and the result register overlap.
// A taken byte waits in the byte register until the result register has room;
// its result, if any, is then registered and valid on the master side.
// When the receiver stalls, the result register holds and the byte register
// fills; after that s_tready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, restarts parsing
// at the version field and sets the limit back to 20.
`timescale 1ns / 1ps
`default_nettype none

module version_negotiation_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cid_limit_wr_en,
  input  wire logic [7:0]  cid_limit_wr_data,
  // packet bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // packet_end
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [31:0] value, [47:32] position, [50:48] status
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast    // last
);
  import vnp_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     space;
  logic     fire;
  logic     res_valid;
  res_t     res;
  res_t     m_res;

  assign s_item = '{data_byte: s_tdata, packet_end: s_tlast};

  // a held byte is processed when the result register has room
  assign fire = item_valid && space;

  vnp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (fire)
  );

  vnp_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .cid_limit_wr_en   (cid_limit_wr_en),
    .cid_limit_wr_data (cid_limit_wr_data),
    .fire              (fire),
    .item              (item),
    .res_valid         (res_valid),
    .res               (res)
  );

  vnp_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (fire && res_valid),
    .res_in  (res),
    .space   (space),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  // pack the result transaction
  assign m_tdata = {5'd0, m_res.status, m_res.position, m_res.value};
  assign m_tuser = m_res.kind;
  assign m_tlast = m_res.last;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import vnp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTES_PER_SETTING = 100;

  // one row of the directed packet bytes
  typedef struct packed {
    logic [7:0] data;
    logic       last_byte;
    logic       known;
    res_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cid_limit_wr_en = 1'b0;
  logic [7:0]  cid_limit_wr_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tlast = 1'b0;   // packet_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;          // [31:0] value, [47:32] position, [50:48] status
  logic [2:0]  m_tuser;          // [2:0] kind
  logic        m_tlast;          // last

  version_negotiation_parser_top u_top (
    .clk               (clk),
    .rst               (rst),
    .cid_limit_wr_en   (cid_limit_wr_en),
    .cid_limit_wr_data (cid_limit_wr_data),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tlast           (s_tlast),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast)
  );

  always #2 clk = ~clk;

  // parser mirror state
  logic [7:0]  cid_limit_q = CID_LIMIT_RESET;
  phase_t      ph = PH_VER;
  logic [7:0]  remaining = 8'd0;
  logic [1:0]  nbytes = 2'd0;
  logic [23:0] acc = 24'd0;
  logic [15:0] idx = 16'd0;
  logic        discard = 1'b0;

  res_t        expected_results [$];
  int unsigned failures = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  logic [15:0] ready_pat = 16'hffff;
  logic [5:0]  pat_age = 6'd0;
  res_t        got, want;

  dir_row_t directed_rows [27] = '{
    // smallest packet: zero version, both ids empty, no versions listed
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{K_END, 32'd0, 16'd0, S_OK, 1'b1}},
    // nonzero version on the fourth byte wins over the early end
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b1, '{K_ERR, 32'd0, 16'd0, S_VER_NZ, 1'b1}},
    // dcid length 21 over the reset limit wins over the early end
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h15, 1'b1, 1'b1, '{K_ERR, 32'd0, 16'd0, S_DCID_LONG, 1'b1}},
    // one dcid byte, one scid byte, one version word ending the packet
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0}, '{8'haa, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0}, '{8'hbb, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0}, '{8'h34, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0}, '{8'h78, 1'b1, 1'b0, '0}
  };

  function automatic void restart_parse();
    ph = PH_VER;
    remaining = 8'd0;
    nbytes = 2'd0;
    acc = 24'd0;
    idx = 16'd0;
    discard = 1'b0;
  endfunction

  // queue one expected result behind the others
  function automatic void enqueue_result(input res_t r);
    expected_results = {expected_results, r};
  endfunction

  // error result; bytes up to the packet end are dropped
  function automatic res_t abort_packet(input status_t s, input logic e);
    restart_parse();
    if (!e) discard = 1'b1;
    return '{K_ERR, 32'd0, 16'd0, s, 1'b1};
  endfunction

  // advance the parser mirror by one byte, returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic e, output res_t r);
    logic [31:0] word;
    r = '0;
    if (discard) begin
      if (e) restart_parse();
      return 1'b0;
    end
    case (ph)
      PH_DLEN: begin
        if (b > cid_limit_q) begin
          r = abort_packet(S_DCID_LONG, e);
          return 1'b1;
        end
        if (e) begin
          r = abort_packet(S_TRUNC, e);
          return 1'b1;
        end
        remaining = b;
        idx = 16'd0;
        ph = (b != 8'd0) ? PH_DCID : PH_SLEN;
        return 1'b0;
      end
      PH_DCID: begin
        if (e) begin
          r = abort_packet(S_TRUNC, e);
          return 1'b1;
        end
        r = '{K_DCID, {24'd0, b}, idx, S_OK, 1'b0};
        idx = idx + 16'd1;
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) ph = PH_SLEN;
        return 1'b1;
      end
      PH_SLEN: begin
        if (b > cid_limit_q) begin
          r = abort_packet(S_SCID_LONG, e);
          return 1'b1;
        end
        if (e) begin
          if (b != 8'd0) begin
            r = abort_packet(S_TRUNC, e);
            return 1'b1;
          end
          r = '{K_END, 32'd0, 16'd0, S_OK, 1'b1};
          restart_parse();
          return 1'b1;
        end
        remaining = b;
        idx = 16'd0;
        nbytes = 2'd0;
        acc = 24'd0;
        ph = (b != 8'd0) ? PH_SCID : PH_LIST;
        return 1'b0;
      end
      PH_SCID: begin
        if (e && remaining != 8'd1) begin
          r = abort_packet(S_TRUNC, e);
          return 1'b1;
        end
        r = '{K_SCID, {24'd0, b}, idx, S_OK, e};
        if (e) begin
          restart_parse();
          return 1'b1;
        end
        idx = idx + 16'd1;
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) begin
          ph = PH_LIST;
          idx = 16'd0;
          nbytes = 2'd0;
          acc = 24'd0;
        end
        return 1'b1;
      end
      PH_LIST: begin
        if (nbytes < 2'd3) begin
          acc = {acc[15:0], b};
          nbytes = nbytes + 2'd1;
          // partial word at the end is dropped
          if (e) begin
            r = '{K_END, 32'd0, idx, S_OK, 1'b1};
            restart_parse();
            return 1'b1;
          end
          return 1'b0;
        end
        word = {acc, b};
        r = '{K_WORD, word, idx, S_OK, e};
        if (idx != 16'hffff) idx = idx + 16'd1;
        nbytes = 2'd0;
        acc = 24'd0;
        if (e) restart_parse();
        return 1'b1;
      end
      default: begin
        // version field
        if (nbytes < 2'd3) begin
          acc = {acc[15:0], b};
          nbytes = nbytes + 2'd1;
          ph = PH_VER;
          if (e) begin
            r = abort_packet(S_TRUNC, e);
            return 1'b1;
          end
          return 1'b0;
        end
        word = {8'd0, acc} | {24'd0, b};
        nbytes = 2'd0;
        acc = 24'd0;
        if (word != 32'd0) begin
          r = abort_packet(S_VER_NZ, e);
          return 1'b1;
        end
        if (e) begin
          r = abort_packet(S_TRUNC, e);
          return 1'b1;
        end
        ph = PH_DLEN;
        return 1'b0;
      end
    endcase
  endfunction

  // one byte transaction, then maybe a gap between bursts
  task automatic send_byte(input logic [7:0] b, input logic e, input logic known,
                           input res_t typed);
    res_t r;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= e;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (parse_byte(b, e, r)) enqueue_result(known ? typed : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // hold off until every result is in and the pipeline has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain();
    cid_limit_wr_en   <= 1'b1;
    cid_limit_wr_data <= v;
    @(posedge clk);
    cid_limit_wr_en <= 1'b0;
    cid_limit_q = v;
  endtask

  function automatic logic [7:0] pick_len(input bit too_long);
    if (too_long && cid_limit_q < 8'd255)
      return 8'($urandom_range(int'(cid_limit_q) + 1, 255));
    if ($urandom_range(0, 9) == 0) return cid_limit_q;
    return 8'($urandom_range(0, (cid_limit_q < 8'd6) ? int'(cid_limit_q) : 6));
  endfunction

  // mostly well-formed packets, some with bad fields, cut short, or plain noise
  task automatic random_packet();
    logic [7:0] pkt [$];
    logic [7:0] len;
    int unsigned sel, cut, n;
    sel = $urandom_range(0, 99);
    if (sel >= 94) begin
      n = $urandom_range(1, 12);
      repeat (n) pkt = {pkt, 8'($urandom)};
    end else begin
      repeat (4) pkt = {pkt, 8'h00};
      if (sel < 6) pkt[$urandom_range(0, 3)] = 8'($urandom_range(1, 255));
      len = pick_len(sel >= 6 && sel < 12);
      pkt = {pkt, len};
      repeat (len) pkt = {pkt, 8'($urandom)};
      len = pick_len(sel >= 12 && sel < 18);
      pkt = {pkt, len};
      repeat (len) pkt = {pkt, 8'($urandom)};
      n = 4 * $urandom_range(0, 5) + $urandom_range(0, 3);
      repeat (n) pkt = {pkt, 8'($urandom)};
    end
    cut = pkt.size();
    if (sel >= 18 && sel < 32) cut = $urandom_range(1, pkt.size());
    for (int i = 0; i < cut; i++) send_byte(pkt[i], i == cut - 1, 1'b0, '0);
    packets++;
  endtask

  // receiver stall pattern, reloaded each time the pattern age counter wraps
  always @(posedge clk) begin
    pat_age <= pat_age + 6'd1;
    if (pat_age == 6'd0)
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
    else
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    m_tready <= ready_pat[0];
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind_t'(m_tuser), m_tdata[31:0], m_tdata[47:32],
              status_t'(m_tdata[50:48]), m_tlast};
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d value %h", m_tuser, m_tdata[31:0]);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          failures++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, got.value);
          failures++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position);
          failures++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          failures++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    logic [7:0] limits [5];
    limits = '{CID_LIMIT_RESET, 8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed packets at the reset limit
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last_byte,
                directed_rows[i].known, directed_rows[i].want);

    // random packets across several limit settings, extremes included
    foreach (limits[p]) begin
      if (p != 0) set_limit(limits[p]);
      mark = bytes_sent;
      while (bytes_sent - mark < BYTES_PER_SETTING) random_packet();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d packets, %0d bytes, %0d results checked", packets + 4,
             bytes_sent, results_checked);
    $display("cid_limit settings 20, 0, 255, %0d and 1, with stalls on both sides",
             limits[3]);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/vnp_pkg.sv
rtl/vnp_in_stage.sv
rtl/vnp_parser.sv
rtl/vnp_out_reg.sv
rtl/version_negotiation_parser_top.sv
tb/tb.sv
